// File: rtl/core/gbba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbba_pkg
// shared types, constants and helpers of the goal block bitmap allocator
// ----------------------------------------------------------------------------
package gbba_pkg;

  localparam int MAX_GROUPS_DEF       = 16;
  localparam int MAX_GROUP_BLOCKS_DEF = 8192;
  localparam int WORD_W               = 32;
  localparam int BLK_W                = 18;
  localparam int STAT_W               = 3;
  localparam int PADDR_W              = 5;
  localparam logic [BLK_W-1:0] TOTAL_MAX = 18'h3FFFF;

  // request kinds
  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
  localparam logic [STAT_W-1:0] ST_RESV     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NONE     = 3'd2;
  localparam logic [STAT_W-1:0] ST_PAST     = 3'd3;
  localparam logic [STAT_W-1:0] ST_ZONE     = 3'd4;
  localparam logic [STAT_W-1:0] ST_ALREADY  = 3'd5;

  // register indexes
  typedef enum logic [2:0] {
    REG_FDB          = 3'd0,
    REG_BLOCKS_TOTAL = 3'd1,
    REG_GSIZE_LOG2   = 3'd2,
    REG_GROUP_COUNT  = 3'd3,
    REG_RESERVED     = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic             fdb;
    logic [BLK_W-1:0] blocks_total;
    logic [3:0]       gsize_log2;
    logic [4:0]       group_count;
    logic [BLK_W-1:0] reserved;
  } cfg_t;

  // index of the lowest set bit, 0 when none
  function automatic logic [4:0] lowest_one(input logic [WORD_W-1:0] v);
    logic [4:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) idx = 5'(i);
    end
    return idx;
  endfunction

endpackage

// File: rtl/core/gbba_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbba_regs
// configuration registers behind the apb-style port
// ----------------------------------------------------------------------------
module gbba_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gbba_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output gbba_pkg::cfg_t                cfg
);
  import gbba_pkg::*;

  cfg_t cfg_r;
  logic wr_stb;

  assign pready = 1'b1;
  assign wr_stb = psel && penable && pwrite;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fdb          <= 1'b1;
      cfg_r.blocks_total <= 18'd131073 & TOTAL_MAX;
      cfg_r.gsize_log2   <= 4'd13;
      cfg_r.group_count  <= 5'd16;
      cfg_r.reserved     <= '0;
    end else if (wr_stb) begin
      case (paddr[4:2])
        REG_FDB:          cfg_r.fdb          <= pwdata[0];
        REG_BLOCKS_TOTAL: cfg_r.blocks_total <= pwdata[BLK_W-1:0];
        REG_GSIZE_LOG2:   cfg_r.gsize_log2   <= pwdata[3:0];
        REG_GROUP_COUNT:  cfg_r.group_count  <= pwdata[4:0];
        REG_RESERVED:     cfg_r.reserved     <= pwdata[BLK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_FDB:          prdata = {31'd0, cfg_r.fdb};
      REG_BLOCKS_TOTAL: prdata = {14'd0, cfg_r.blocks_total};
      REG_GSIZE_LOG2:   prdata = {28'd0, cfg_r.gsize_log2};
      REG_GROUP_COUNT:  prdata = {27'd0, cfg_r.group_count};
      REG_RESERVED:     prdata = {14'd0, cfg_r.reserved};
      default:          prdata = '0;
    endcase
  end

endmodule

// File: rtl/core/goal_block_bitmap_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// goal_block_bitmap_allocator_core
// goal-directed block allocator over a per-group used bitmap
// ----------------------------------------------------------------------------
// The block keeps a used bitmap (bit set = block in use) in a single-port
// style memory of 32-bit words, MAX_GROUP_BLOCKS/32 words per group, plus a
// free count per group and a total free count. One word is taken at a time.
// A free passes through the idle, decode, free and finish states; an
// allocate that finds its goal free passes through idle, decode, check,
// goal, write and finish; a refused or out-of-zone item goes from decode
// straight to finish. The near window adds one word read when it crosses
// into the next word. A group scan streams one bitmap word per cycle
// through the memory read port; the walk over other groups checks their
// free counts one group at a time. The block holds in_stall high until the
// item is done; a finished result waits in the output register while the
// next word is accepted. After reset a clearing pass sets every bitmap
// word, with in_stall high. Configuration should be written only while no
// item is in flight.
// ----------------------------------------------------------------------------
module goal_block_bitmap_allocator_core #(
  parameter int MAX_GROUPS       = gbba_pkg::MAX_GROUPS_DEF,
  parameter int MAX_GROUP_BLOCKS = gbba_pkg::MAX_GROUP_BLOCKS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [gbba_pkg::BLK_W-1:0]    in_block_or_goal,
  input  logic                          in_privileged,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gbba_pkg::BLK_W-1:0]    out_block_number,
  output logic [gbba_pkg::STAT_W-1:0]   out_status,
  output logic [gbba_pkg::BLK_W-1:0]    out_free_blocks,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gbba_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import gbba_pkg::*;

  localparam int GB_LOG2   = $clog2(MAX_GROUP_BLOCKS);
  localparam int WPG       = MAX_GROUP_BLOCKS / WORD_W;
  localparam int MAP_WORDS = MAX_GROUPS * WPG;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int GW        = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int WOW       = (WPG > 1) ? $clog2(WPG) : 1;
  localparam int GCW       = $clog2(MAX_GROUPS + 1);
  localparam int CNTW      = $clog2(MAX_GROUP_BLOCKS + 1);
  localparam int LGW       = $clog2(GB_LOG2 + 1);
  localparam int EW        = (GB_LOG2 + GW + 1 > BLK_W) ? GB_LOG2 + GW + 1 : BLK_W;

  typedef enum logic [10:0] {
    S_CLR   = 11'b000_0000_0001,
    S_IDLE  = 11'b000_0000_0010,
    S_DEC   = 11'b000_0000_0100,
    S_CHK   = 11'b000_0000_1000,
    S_GOAL  = 11'b000_0001_0000,
    S_NEAR2 = 11'b000_0010_0000,
    S_WALK  = 11'b000_0100_0000,
    S_SCAN  = 11'b000_1000_0000,
    S_WR    = 11'b001_0000_0000,
    S_FREE  = 11'b010_0000_0000,
    S_FIN   = 11'b100_0000_0000
  } state_t;

  cfg_t cfg;

  gbba_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // bitmap memory
  logic [WORD_W-1:0] map_mem [MAP_WORDS];
  logic [WORD_W-1:0] rd_data_r;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [WORD_W-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= map_mem[rd_addr];
  end

  // control registers
  state_t            state_r, state_nxt;
  logic [AW-1:0]     clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              data_vld_r, data_vld_nxt;
  logic              issue_done_r, issue_done_nxt;
  logic              bit_fnd_r, bit_fnd_nxt;
  logic [CNTW-1:0]   cnt_r [MAX_GROUPS];
  logic              cnt_we;
  logic [CNTW-1:0]   cnt_wv;
  logic [BLK_W-1:0]  total_r, total_nxt;

  // item registers
  logic              kind_r, kind_nxt;
  logic [BLK_W-1:0]  arg_r, arg_nxt;
  logic              priv_r, priv_nxt;
  logic [GW-1:0]     g_r, g_nxt;
  logic [WOW-1:0]    w_r, w_nxt;
  logic [4:0]        p_r, p_nxt;
  logic              jnz_r, jnz_nxt;
  logic              walk_ph_r, walk_ph_nxt;
  logic [GCW-1:0]    walk_k_r, walk_k_nxt;
  logic [WOW-1:0]    scan_iss_r, scan_iss_nxt;
  logic [WOW-1:0]    data_wo_r, data_wo_nxt;
  logic [WOW-1:0]    first_wo_r, first_wo_nxt;
  logic [WOW-1:0]    hit_wo_r, hit_wo_nxt;
  logic [4:0]        hit_bit_r, hit_bit_nxt;
  logic [WORD_W-1:0] hit_data_r, hit_data_nxt;
  logic [BLK_W-1:0]  res_blk_r, res_blk_nxt;
  logic [STAT_W-1:0] res_st_r, res_st_nxt;
  logic [BLK_W-1:0]  out_blk_r, out_blk_nxt;
  logic [STAT_W-1:0] out_st_r, out_st_nxt;
  logic [BLK_W-1:0]  out_free_r, out_free_nxt;

  // effective geometry, clamped to the supported range
  logic [LGW-1:0]    lg_eff;
  logic [GCW-1:0]    gc_eff;
  logic [WOW-1:0]    last_wo;

  always_comb begin
    if (cfg.gsize_log2 < 4'd5)                    lg_eff = LGW'(5);
    else if (int'(cfg.gsize_log2) > GB_LOG2)      lg_eff = LGW'(GB_LOG2);
    else                                          lg_eff = LGW'(cfg.gsize_log2);
    if (cfg.group_count == 5'd0)                  gc_eff = GCW'(1);
    else if (int'(cfg.group_count) > MAX_GROUPS)  gc_eff = GCW'(MAX_GROUPS);
    else                                          gc_eff = GCW'(cfg.group_count);
  end

  assign last_wo = WOW'((32'd1 << (lg_eff - LGW'(5))) - 32'd1);

  // decode of the block or goal number
  logic              dec_inz, dec_ok;
  logic [BLK_W-1:0]  dec_rel, dec_gfull, dec_gmask;
  logic [GB_LOG2-1:0] dec_j;
  logic [GW-1:0]     dec_grp;
  logic [WOW-1:0]    dec_w;

  assign dec_inz   = (arg_r >= BLK_W'(cfg.fdb)) && (arg_r < cfg.blocks_total);
  assign dec_rel   = arg_r - BLK_W'(cfg.fdb);
  assign dec_gfull = dec_rel >> lg_eff;
  assign dec_ok    = dec_inz && (dec_gfull < BLK_W'(gc_eff));
  assign dec_gmask = (BLK_W'(1) << lg_eff) - BLK_W'(1);
  assign dec_j     = dec_ok ? GB_LOG2'(dec_rel & dec_gmask) : '0;
  assign dec_grp   = dec_ok ? GW'(dec_gfull) : '0;
  assign dec_w     = WOW'(dec_j >> 5);

  // found block number in full width
  logic [EW-1:0]     blk_sum;
  assign blk_sum = ((EW'(hit_wo_r) << 5) | EW'(hit_bit_r)) + (EW'(g_r) << lg_eff)
                 + EW'(cfg.fdb);

  function automatic logic [AW-1:0] map_addr(input logic [GW-1:0] g,
                                             input logic [WOW-1:0] wo);
    return AW'(AW'(g) * AW'(WPG) + AW'(wo));
  endfunction

  logic [CNTW-1:0]   cnt_cur;
  assign cnt_cur = cnt_r[g_r];

  always_comb begin
    logic [WORD_W-1:0] near;
    logic [WORD_W-1:0] bitfree;
    logic              first;
    logic              byte_hit;
    logic [1:0]        byte_idx;

    state_nxt      = state_r;
    clr_nxt        = clr_r;
    out_valid_nxt  = out_valid_r;
    data_vld_nxt   = data_vld_r;
    issue_done_nxt = issue_done_r;
    bit_fnd_nxt    = bit_fnd_r;
    total_nxt      = total_r;
    kind_nxt       = kind_r;
    arg_nxt        = arg_r;
    priv_nxt       = priv_r;
    g_nxt          = g_r;
    w_nxt          = w_r;
    p_nxt          = p_r;
    jnz_nxt        = jnz_r;
    walk_ph_nxt    = walk_ph_r;
    walk_k_nxt     = walk_k_r;
    scan_iss_nxt   = scan_iss_r;
    data_wo_nxt    = data_wo_r;
    first_wo_nxt   = first_wo_r;
    hit_wo_nxt     = hit_wo_r;
    hit_bit_nxt    = hit_bit_r;
    hit_data_nxt   = hit_data_r;
    res_blk_nxt    = res_blk_r;
    res_st_nxt     = res_st_r;
    out_blk_nxt    = out_blk_r;
    out_st_nxt     = out_st_r;
    out_free_nxt   = out_free_r;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = '0;
    cnt_we         = 1'b0;
    cnt_wv         = cnt_cur;
    near           = '0;
    bitfree        = '0;
    first          = 1'b0;
    byte_hit       = 1'b0;
    byte_idx       = '0;

    // result word leaves
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(MAP_WORDS - 1)) state_nxt = S_IDLE;
      end

      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = in_kind;
          arg_nxt   = in_block_or_goal;
          priv_nxt  = in_privileged;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        g_nxt       = dec_grp;
        w_nxt       = dec_w;
        p_nxt       = dec_j[4:0];
        jnz_nxt     = (dec_j != '0);
        walk_ph_nxt = 1'b0;
        walk_k_nxt  = '0;
        res_blk_nxt = '0;
        if (kind_r == KIND_FREE) begin
          if (!dec_ok) begin
            res_st_nxt = ST_ZONE;
            state_nxt  = S_FIN;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = map_addr(dec_grp, dec_w);
            state_nxt = S_FREE;
          end
        end else if (!priv_r && total_r <= cfg.reserved) begin
          res_st_nxt = ST_RESV;
          state_nxt  = S_FIN;
        end else begin
          state_nxt = S_CHK;
        end
      end

      S_CHK: begin
        if (cnt_cur == '0) begin
          walk_ph_nxt = 1'b1;
          state_nxt   = S_WALK;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = map_addr(g_r, w_r);
          state_nxt = S_GOAL;
        end
      end

      S_GOAL: begin
        near = ~rd_data_r & (32'hFFFF_FFFF << p_r << 1);
        if (!rd_data_r[p_r]) begin
          hit_wo_nxt   = w_r;
          hit_bit_nxt  = p_r;
          hit_data_nxt = rd_data_r;
          state_nxt    = S_WR;
        end else if (jnz_r && (near != '0)) begin
          hit_wo_nxt   = w_r;
          hit_bit_nxt  = lowest_one(near);
          hit_data_nxt = rd_data_r;
          state_nxt    = S_WR;
        end else if (jnz_r && (w_r != last_wo)) begin
          // near window runs into the next word
          rd_en     = 1'b1;
          rd_addr   = map_addr(g_r, WOW'(w_r + 1'b1));
          state_nxt = S_NEAR2;
        end else begin
          scan_iss_nxt   = w_r;
          first_wo_nxt   = w_r;
          data_vld_nxt   = 1'b0;
          issue_done_nxt = 1'b0;
          bit_fnd_nxt    = 1'b0;
          state_nxt      = S_SCAN;
        end
      end

      S_NEAR2: begin
        near = ~rd_data_r & (32'hFFFF_FFFF >> (5'd31 - p_r));
        if (near != '0) begin
          hit_wo_nxt   = WOW'(w_r + 1'b1);
          hit_bit_nxt  = lowest_one(near);
          hit_data_nxt = rd_data_r;
          state_nxt    = S_WR;
        end else begin
          scan_iss_nxt   = w_r;
          first_wo_nxt   = w_r;
          data_vld_nxt   = 1'b0;
          issue_done_nxt = 1'b0;
          bit_fnd_nxt    = 1'b0;
          state_nxt      = S_SCAN;
        end
      end

      S_WALK: begin
        if ((walk_k_r != '0) && (cnt_cur != '0)) begin
          scan_iss_nxt   = '0;
          first_wo_nxt   = '0;
          p_nxt          = '0;
          data_vld_nxt   = 1'b0;
          issue_done_nxt = 1'b0;
          bit_fnd_nxt    = 1'b0;
          state_nxt      = S_SCAN;
        end else if (walk_k_r >= gc_eff) begin
          res_st_nxt = ST_NONE;
          state_nxt  = S_FIN;
        end else begin
          g_nxt      = (int'(g_r) + 1 >= int'(gc_eff)) ? '0 : GW'(g_r + 1'b1);
          walk_k_nxt = walk_k_r + 1'b1;
        end
      end

      S_SCAN: begin
        // evaluate the word read in the previous cycle
        if (data_vld_r) begin
          first   = (data_wo_r == first_wo_r);
          bitfree = ~rd_data_r & (first ? (32'hFFFF_FFFF << p_r) : 32'hFFFF_FFFF);
          for (int b = 3; b >= 0; b--) begin
            if ((rd_data_r[8*b +: 8] == 8'd0) && (!first || (2'(b) >= p_r[4:3]))) begin
              byte_hit = 1'b1;
              byte_idx = 2'(b);
            end
          end
          if (byte_hit) begin
            hit_wo_nxt   = data_wo_r;
            hit_bit_nxt  = {byte_idx, 3'd0};
            hit_data_nxt = rd_data_r;
            state_nxt    = S_WR;
          end else begin
            if (!bit_fnd_r && (bitfree != '0)) begin
              hit_wo_nxt   = data_wo_r;
              hit_bit_nxt  = lowest_one(bitfree);
              hit_data_nxt = rd_data_r;
              bit_fnd_nxt  = 1'b1;
            end
            if (data_wo_r == last_wo) begin
              if (bit_fnd_r || (bitfree != '0)) begin
                state_nxt = S_WR;
              end else if (walk_ph_r) begin
                res_st_nxt = ST_NONE;
                state_nxt  = S_FIN;
              end else begin
                // goal group has no usable bit, go on to the other groups
                walk_ph_nxt = 1'b1;
                walk_k_nxt  = '0;
                state_nxt   = S_WALK;
              end
            end
          end
        end
        // stream the next word
        if (!issue_done_r) begin
          rd_en        = 1'b1;
          rd_addr      = map_addr(g_r, scan_iss_r);
          data_vld_nxt = 1'b1;
          data_wo_nxt  = scan_iss_r;
          if (scan_iss_r == last_wo) issue_done_nxt = 1'b1;
          else                       scan_iss_nxt   = scan_iss_r + 1'b1;
        end else begin
          data_vld_nxt = 1'b0;
        end
      end

      S_WR: begin
        // the bit is marked used even when the block lies past the total
        wr_en   = 1'b1;
        wr_addr = map_addr(g_r, hit_wo_r);
        wr_data = hit_data_r | (32'h1 << hit_bit_r);
        if (blk_sum >= EW'(cfg.blocks_total)) begin
          res_st_nxt  = ST_PAST;
          res_blk_nxt = '0;
        end else begin
          res_st_nxt  = ST_OK;
          res_blk_nxt = BLK_W'(blk_sum);
          cnt_we      = 1'b1;
          cnt_wv      = (cnt_cur != '0) ? cnt_cur - 1'b1 : cnt_cur;
          if (total_r != '0) total_nxt = total_r - 1'b1;
        end
        state_nxt = S_FIN;
      end

      S_FREE: begin
        if (!rd_data_r[p_r]) begin
          res_st_nxt = ST_ALREADY;
        end else begin
          wr_en      = 1'b1;
          wr_addr    = map_addr(g_r, w_r);
          wr_data    = rd_data_r & ~(32'h1 << p_r);
          res_st_nxt = ST_OK;
          cnt_we     = 1'b1;
          cnt_wv     = (cnt_cur < CNTW'(MAX_GROUP_BLOCKS)) ? cnt_cur + 1'b1 : cnt_cur;
          if (total_r != TOTAL_MAX) total_nxt = total_r + 1'b1;
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_blk_nxt   = res_blk_r;
          out_st_nxt    = res_st_r;
          out_free_nxt  = total_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      clr_r        <= '0;
      out_valid_r  <= 1'b0;
      data_vld_r   <= 1'b0;
      issue_done_r <= 1'b0;
      bit_fnd_r    <= 1'b0;
      total_r      <= '0;
      g_r          <= '0;
      for (int i = 0; i < MAX_GROUPS; i++) cnt_r[i] <= '0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      out_valid_r  <= out_valid_nxt;
      data_vld_r   <= data_vld_nxt;
      issue_done_r <= issue_done_nxt;
      bit_fnd_r    <= bit_fnd_nxt;
      total_r      <= total_nxt;
      g_r          <= g_nxt;
      if (cnt_we) cnt_r[g_r] <= cnt_wv;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    arg_r      <= arg_nxt;
    priv_r     <= priv_nxt;
    w_r        <= w_nxt;
    p_r        <= p_nxt;
    jnz_r      <= jnz_nxt;
    walk_ph_r  <= walk_ph_nxt;
    walk_k_r   <= walk_k_nxt;
    scan_iss_r <= scan_iss_nxt;
    data_wo_r  <= data_wo_nxt;
    first_wo_r <= first_wo_nxt;
    hit_wo_r   <= hit_wo_nxt;
    hit_bit_r  <= hit_bit_nxt;
    hit_data_r <= hit_data_nxt;
    res_blk_r  <= res_blk_nxt;
    res_st_r   <= res_st_nxt;
    out_blk_r  <= out_blk_nxt;
    out_st_r   <= out_st_nxt;
    out_free_r <= out_free_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_block_number = out_blk_r;
  assign out_status       = out_st_r;
  assign out_free_blocks  = out_free_r;

  // checks
  a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r))
    else $error("sequencer state not one-hot");

  a_clr_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> in_stall)
    else $error("word accepted during clearing pass");

  a_wr_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |=> (state_r == S_FIN))
    else $error("bitmap write not followed by result");

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_cur <= CNTW'(MAX_GROUP_BLOCKS))
    else $error("group free count above group size");

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the goal block bitmap allocator core
// ----------------------------------------------------------------------------
// A bit-level allocator mirror predicts every result word. A directed table
// covers reset behavior, frees, double frees, goal hits, out-of-zone goals,
// reserve refusal and group walks; then randomized phases under several
// register settings mix frees with allocations near random goals.
// ----------------------------------------------------------------------------
module tb;
  import gbba_pkg::*;

  localparam int NGRP    = MAX_GROUPS_DEF;
  localparam int GBLK    = MAX_GROUP_BLOCKS_DEF;
  localparam int NBITS   = NGRP * GBLK;

  logic clk, rst_n;
  logic in_valid, in_stall, in_kind, in_privileged;
  logic [BLK_W-1:0] in_block_or_goal;
  logic out_valid, out_stall;
  logic [BLK_W-1:0] out_block_number, out_free_blocks;
  logic [STAT_W-1:0] out_status;
  logic psel, penable, pwrite, pready;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  goal_block_bitmap_allocator_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_block_or_goal(in_block_or_goal), .in_privileged(in_privileged),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_block_number(out_block_number), .out_status(out_status),
    .out_free_blocks(out_free_blocks),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct {
    logic [BLK_W-1:0]  blk;
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0]  free_cnt;
  } alloc_result_t;

  // allocator mirror
  bit            used_map[NBITS];
  int unsigned   grp_free[NGRP];
  int unsigned   tot_free;
  cfg_t          cfg;
  alloc_result_t pending_results[$];

  int errors = 0;
  int mismatches = 0;
  bit rx_hold = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------- mirror
  function automatic int unsigned eff_log2();
    int unsigned l;
    l = cfg.gsize_log2;
    if (l < 5) l = 5;
    if (l > $clog2(GBLK)) l = $clog2(GBLK);
    return l;
  endfunction

  function automatic int unsigned eff_groups();
    int unsigned g;
    g = cfg.group_count;
    if (g == 0) g = 1;
    if (g > NGRP) g = NGRP;
    return g;
  endfunction

  function automatic bit bit_used(int unsigned g, int unsigned b);
    return used_map[g * GBLK + b];
  endfunction

  // first fully free aligned byte at or after byte 'from', gsz when none
  function automatic int unsigned scan_free_byte(int unsigned g, int unsigned from,
                                                 int unsigned gsz);
    bit hit;
    for (int unsigned by = from; by < gsz / 8; by++) begin
      hit = 1;
      for (int k = 0; k < 8; k++) if (bit_used(g, by * 8 + k)) hit = 0;
      if (hit) return by * 8;
    end
    return gsz;
  endfunction

  function automatic int unsigned scan_free_bit(int unsigned g, int unsigned from,
                                                int unsigned gsz);
    for (int unsigned b = from; b < gsz; b++) if (!bit_used(g, b)) return b;
    return gsz;
  endfunction

  function automatic alloc_result_t alloc_near_goal(int unsigned goal, bit priv);
    alloc_result_t r;
    int unsigned lg, gsz, gc, rel, grp, j, g, k, blk;
    bit found;
    lg = eff_log2(); gsz = 1 << lg; gc = eff_groups();
    found = 0;
    r.blk = '0;
    r.status = ST_OK;
    if (!priv && tot_free <= cfg.reserved) begin
      r.status = ST_RESV; r.free_cnt = BLK_W'(tot_free); return r;
    end
    rel = (goal < cfg.fdb || goal >= cfg.blocks_total) ? 0 : goal - cfg.fdb;
    grp = rel >> lg;
    if (grp >= gc) begin
      grp = 0; rel = 0;
    end
    j = rel & (gsz - 1);
    g = grp;
    if (grp_free[grp] > 0) begin
      if (!bit_used(grp, j)) found = 1;
      else begin
        if (j != 0) begin
          for (k = 1; k <= 32 && j + k < gsz; k++)
            if (!bit_used(grp, j + k)) begin
              j += k; found = 1; break;
            end
        end
        if (!found) begin
          k = scan_free_byte(grp, j >> 3, gsz);
          if (k >= gsz) k = scan_free_bit(grp, j, gsz);
          if (k < gsz) begin
            j = k; found = 1;
          end
        end
      end
    end
    if (!found) begin
      for (k = 0; k < gc; k++) begin
        g = (g + 1 >= gc) ? 0 : g + 1;
        if (grp_free[g] > 0) break;
      end
      if (k >= gc) begin
        r.status = ST_NONE; r.free_cnt = BLK_W'(tot_free); return r;
      end
      j = scan_free_byte(g, 0, gsz);
      if (j >= gsz) j = scan_free_bit(g, 0, gsz);
      if (j >= gsz) begin
        r.status = ST_NONE; r.free_cnt = BLK_W'(tot_free); return r;
      end
    end
    used_map[g * GBLK + j] = 1;
    blk = j + g * gsz + cfg.fdb;
    if (blk >= cfg.blocks_total) begin
      r.status = ST_PAST; r.free_cnt = BLK_W'(tot_free); return r;
    end
    if (grp_free[g] > 0) grp_free[g]--;
    if (tot_free > 0) tot_free--;
    r.blk = BLK_W'(blk);
    r.free_cnt = BLK_W'(tot_free);
    return r;
  endfunction

  function automatic alloc_result_t release_block(int unsigned blk);
    alloc_result_t r;
    int unsigned lg, gsz, rel, g, b;
    lg = eff_log2(); gsz = 1 << lg;
    r.blk = '0;
    r.status = ST_OK;
    if (blk < cfg.fdb || blk >= cfg.blocks_total) r.status = ST_ZONE;
    else begin
      rel = blk - cfg.fdb;
      g = rel >> lg;
      b = rel & (gsz - 1);
      if (g >= eff_groups()) r.status = ST_ZONE;
      else if (!bit_used(g, b)) r.status = ST_ALREADY;
      else begin
        used_map[g * GBLK + b] = 0;
        if (grp_free[g] < GBLK) grp_free[g]++;
        if (tot_free < TOTAL_MAX) tot_free++;
      end
    end
    r.free_cnt = BLK_W'(tot_free);
    return r;
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic cfg_write(reg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= PADDR_W'(idx) << 2; pwdata <= val;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_FDB:          cfg.fdb = val[0];
      REG_BLOCKS_TOTAL: cfg.blocks_total = val[BLK_W-1:0];
      REG_GSIZE_LOG2:   cfg.gsize_log2 = val[3:0];
      REG_GROUP_COUNT:  cfg.group_count = val[4:0];
      default:          cfg.reserved = val[BLK_W-1:0];
    endcase
  endtask

  task automatic set_cfg(bit fdb, int unsigned total, int unsigned lg, int unsigned gc,
                         int unsigned resv);
    cfg_write(REG_FDB, 32'(fdb));
    cfg_write(REG_BLOCKS_TOTAL, total);
    cfg_write(REG_GSIZE_LOG2, lg);
    cfg_write(REG_GROUP_COUNT, gc);
    cfg_write(REG_RESERVED, resv);
  endtask

  // one word offered; in_valid stays up while the burst goes on
  task automatic send_word(bit kind, int unsigned arg, bit priv, bit has_exp,
                           alloc_result_t exp_typed, bit keep_valid);
    alloc_result_t r;
    in_valid <= 1; in_kind <= kind; in_block_or_goal <= arg[BLK_W-1:0];
    in_privileged <= priv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = kind ? release_block(arg) : alloc_near_goal(arg, priv);
    if (has_exp && (r.blk !== exp_typed.blk || r.status !== exp_typed.status ||
        r.free_cnt !== exp_typed.free_cnt)) begin
      errors++;
      $display("directed row disagrees with mirror: kind %0d arg %0d", kind, arg);
    end
    pending_results.push_back(r);
    @(negedge clk);
    if (!keep_valid) begin
      in_valid <= 0;
      @(negedge clk);
    end
  endtask

  task automatic drain_results();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("unexpected result word %0d/%0d/%0d",
                                        out_block_number, out_status, out_free_blocks);
      end else begin
        e = pending_results.pop_front();
        if (out_block_number !== e.blk || out_status !== e.status ||
            out_free_blocks !== e.free_cnt) begin
          errors++;
          if (mismatches++ < 10)
            $display("mismatch: exp blk %0d st %0d free %0d, got blk %0d st %0d free %0d",
                     e.blk, e.status, e.free_cnt, out_block_number, out_status,
                     out_free_blocks);
        end
      end
    end
  end

  // receiver stall pattern, with an occasional long hold
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) out_stall <= 1;
      else case ($urandom_range(0, 3))
        0: out_stall <= 0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= ($urandom_range(0, 1) == 1);
      endcase
    end
  end

  // ---------------------------------------------------------------- stimulus
  typedef struct {
    bit kind;
    int unsigned arg;
    bit priv;
    bit typed;
    logic [BLK_W-1:0] blk;
    logic [STAT_W-1:0] status;
    logic [BLK_W-1:0] free_cnt;
  } directed_row_t;

  // reset config: fdb 1, total 131073, 16 groups of 8192, no reserve
  directed_row_t directed_rows[] = '{
    '{KIND_ALLOC, 100,    1'b0, 1'b1, 0, ST_RESV,    0},  // nothing free yet
    '{KIND_ALLOC, 100,    1'b1, 1'b1, 0, ST_NONE,    0},  // privileged, no free groups
    '{KIND_FREE,  0,      1'b0, 1'b1, 0, ST_ZONE,    0},  // below first data block
    '{KIND_FREE,  131073, 1'b0, 1'b1, 0, ST_ZONE,    0},  // at block total
    '{KIND_FREE,  262143, 1'b1, 1'b1, 0, ST_ZONE,    0},  // all ones
    '{KIND_FREE,  1,      1'b0, 1'b1, 0, ST_OK,      1},
    '{KIND_FREE,  1,      1'b0, 1'b1, 0, ST_ALREADY, 1},  // double free
    '{KIND_FREE,  131072, 1'b0, 1'b1, 0, ST_OK,      2},  // last block
    '{KIND_FREE,  50,     1'b0, 1'b1, 0, ST_OK,      3},
    '{KIND_ALLOC, 50,     1'b0, 1'b1, 50, ST_OK,     2},  // goal hit
    '{KIND_ALLOC, 0,      1'b0, 1'b1, 1, ST_OK,      1},  // goal below zone
    '{KIND_ALLOC, 200000, 1'b1, 1'b1, 131072, ST_OK, 0},  // past total, walks groups
    '{KIND_ALLOC, 5,      1'b1, 1'b1, 0, ST_NONE,    0},
    '{KIND_FREE,  8193,   1'b0, 1'b0, 0, 0, 0},           // group start
    '{KIND_FREE,  8200,   1'b0, 1'b0, 0, 0, 0},
    '{KIND_FREE,  8230,   1'b0, 1'b0, 0, 0, 0},
    '{KIND_ALLOC, 8193,   1'b1, 1'b0, 0, 0, 0},
    '{KIND_ALLOC, 8193,   1'b1, 1'b0, 0, 0, 0},           // group start used
    '{KIND_ALLOC, 8201,   1'b1, 1'b0, 0, 0, 0},           // near window
    '{KIND_ALLOC, 8201,   1'b1, 1'b0, 0, 0, 0}            // no free, walk
  };

  int unsigned cur_max_blk;

  task automatic random_phase(int n, int pct_free);
    int burst;
    int unsigned arg;
    bit kind;
    int sent;
    alloc_result_t dummy;
    dummy = '{default: '0};
    sent = 0;
    while (sent < n) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < n; i++) begin
        kind = ($urandom_range(0, 99) < pct_free);
        case ($urandom_range(0, 9))
          0: arg = $urandom_range(0, 262143);            // noise, any bit pattern
          1: arg = $urandom_range(0, 3);
          default: arg = $urandom_range(0, cur_max_blk);
        endcase
        send_word(kind, arg, 1'($urandom_range(0, 1)), 0, dummy,
                  i + 1 < burst && sent + 1 < n);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  initial begin
    alloc_result_t exp_row;
    rst_n = 0; in_valid = 0; in_kind = 0; in_block_or_goal = '0; in_privileged = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    cfg = '{fdb: 1'b1, blocks_total: 18'd131073, gsize_log2: 4'd13,
            group_count: 5'd16, reserved: '0};
    for (int i = 0; i < NBITS; i++) used_map[i] = 1;
    for (int g = 0; g < NGRP; g++) grp_free[g] = 0;
    tot_free = 0;
    repeat (3) @(negedge clk);
    rst_n = 1;

    // directed table under the reset settings
    foreach (directed_rows[i]) begin
      exp_row.blk = directed_rows[i].blk;
      exp_row.status = directed_rows[i].status;
      exp_row.free_cnt = directed_rows[i].free_cnt;
      send_word(directed_rows[i].kind, directed_rows[i].arg, directed_rows[i].priv,
                directed_rows[i].typed, exp_row, 0);
    end
    drain_results();

    // small groups, few blocks: deep scans and group walks stay cheap
    set_cfg(0, 300, 5, 8, 4);
    cur_max_blk = 320;
    random_phase(400, 55);
    drain_results();

    // long receiver hold while words keep coming
    fork
      begin
        rx_hold = 1;
        repeat (300) @(negedge clk);
        rx_hold = 0;
      end
      random_phase(30, 50);
    join
    drain_results();

    // odd sizes: total past the groups, reserve at top, group count zero
    set_cfg(1, 1, 6, 0, 131072);
    cur_max_blk = 70;
    random_phase(80, 50);
    drain_results();
    set_cfg(1, 2000, 7, 31, 0);
    cur_max_blk = 2100;
    random_phase(400, 60);
    drain_results();
    set_cfg(0, 262143, 15, 3, 10);
    cur_max_blk = 300;
    random_phase(150, 50);
    drain_results();
    set_cfg(1, 131073, 13, 16, 0);
    cur_max_blk = 131073;
    random_phase(190, 50);
    drain_results();

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
